>>> rtl/core/prrq_pkg.sv
// Package for the packet receive ring queue.
// Holds the channel word types, status and opcode codes, and default sizes.
// No dependencies.
`default_nettype none

package prrq_pkg;

    localparam int QUEUE_SLOTS_DEF = 16;
    localparam int SLOT_BYTES_DEF  = 2048;

    // Width of the packet_length field on the result channel.
    localparam int PKT_LEN_W = 12;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_DISABLED  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       carries_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [7:0]           out_byte;
        logic [PKT_LEN_W-1:0] packet_length;
        logic                 last;
    } out_item_t;

    // Result fields known at processing time; the byte comes from the store.
    typedef struct packed {
        logic [2:0]           status;
        logic [PKT_LEN_W-1:0] packet_length;
        logic                 last;
        logic                 from_store;
    } res_meta_t;

endpackage

`default_nettype wire

>>> rtl/core/prrq_len_table.sv
// Per-slot length table of the packet receive ring queue.
// Registered read with write forwarding, so the read word always matches the table.
// No dependencies.
`default_nettype none

module prrq_len_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A length committed in the same cycle as it is addressed is forwarded.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/prrq_store.sv
// Packet byte store of the packet receive ring queue.
// One write port and one read port with registered read data.
// No dependencies.
`default_nettype none

module prrq_store #(
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [7:0]               wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [7:0]               rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // The read word holds until the next read, which keeps a stalled result intact.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/prrq_engine.sv
// Ring pointer state and per-word decision logic of the packet receive ring queue.
// Uses prrq_pkg; drives the length table and the byte store ports.
`default_nettype none

module prrq_engine #(
    parameter int QUEUE_SLOTS = 16,
    parameter int SLOT_BYTES  = 2048,
    localparam int SLOT_W     = $clog2(QUEUE_SLOTS),
    localparam int LEN_W      = $clog2(SLOT_BYTES + 1),
    localparam int ADDR_W     = $clog2(QUEUE_SLOTS * SLOT_BYTES)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire prrq_pkg::in_item_t   item,
    input  wire logic                 enabled,
    input  wire logic [LEN_W-1:0]     head_len,
    output prrq_pkg::res_meta_t       meta,
    output logic                      lt_we,
    output logic [SLOT_W-1:0]         lt_waddr,
    output logic [LEN_W-1:0]          lt_wdata,
    output logic [SLOT_W-1:0]         lt_raddr,
    output logic                      st_we,
    output logic [ADDR_W-1:0]         st_waddr,
    output logic [7:0]                st_wdata,
    output logic                      st_re,
    output logic [ADDR_W-1:0]         st_raddr
);
    import prrq_pkg::*;

    localparam int OFF_W = $clog2(SLOT_BYTES);

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [LEN_W-1:0]  write_offset_reg, write_offset_next;
    logic [OFF_W-1:0]  read_offset_reg, read_offset_next;
    logic              dropping_packet_reg, dropping_packet_next;
    logic              mid_packet_reg, mid_packet_next;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [LEN_W-1:0]  off);
        return ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off);
    endfunction

    always_comb
    begin
        logic             drop;
        logic [LEN_W-1:0] woff;
        logic             fits;
        logic [LEN_W-1:0] woff_new;
        logic [LEN_W-1:0] roff_new;
        logic             done;

        drop     = 1'b0;
        woff     = '0;
        fits     = 1'b0;
        woff_new = '0;
        roff_new = '0;
        done     = 1'b0;

        write_slot_next      = write_slot_reg;
        read_slot_next       = read_slot_reg;
        write_offset_next    = write_offset_reg;
        read_offset_next     = read_offset_reg;
        dropping_packet_next = dropping_packet_reg;
        mid_packet_next      = mid_packet_reg;

        meta     = '0;
        lt_we    = 1'b0;
        lt_waddr = write_slot_reg;
        lt_wdata = '0;
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = item.data_byte;
        st_re    = 1'b0;
        st_raddr = '0;

        if (fire)
        begin
            if (!enabled)
            begin
                meta.status = ST_DISABLED;
            end
            else if (item.opcode == OP_PUSH)
            begin
                // The free-slot check happens only on the first word of a packet.
                if (!mid_packet_reg)
                begin
                    drop = (slot_inc(write_slot_reg) == read_slot_reg);
                    woff = '0;
                end
                else
                begin
                    drop = dropping_packet_reg;
                    woff = write_offset_reg;
                end

                if (drop)
                begin
                    mid_packet_next      = !item.last_byte;
                    dropping_packet_next = !item.last_byte;
                    meta.status          = ST_DROPPED;
                    meta.last            = item.last_byte;
                end
                else
                begin
                    dropping_packet_next = 1'b0;
                    fits     = (woff < LEN_W'(SLOT_BYTES));
                    woff_new = woff;
                    if (item.carries_byte)
                    begin
                        if (fits)
                        begin
                            st_we    = 1'b1;
                            st_waddr = byte_addr(write_slot_reg, woff);
                            woff_new = woff + LEN_W'(1);
                        end
                        else
                        begin
                            meta.status = ST_TRUNCATED;
                        end
                    end

                    if (item.last_byte)
                    begin
                        lt_we              = 1'b1;
                        lt_wdata           = woff_new;
                        write_slot_next    = slot_inc(write_slot_reg);
                        mid_packet_next    = 1'b0;
                        write_offset_next  = '0;
                        meta.packet_length = PKT_LEN_W'(woff_new);
                        meta.last          = 1'b1;
                    end
                    else
                    begin
                        mid_packet_next   = 1'b1;
                        write_offset_next = woff_new;
                    end
                end
            end
            else
            begin
                if (read_slot_reg == write_slot_reg)
                begin
                    meta.status = ST_EMPTY;
                end
                else
                begin
                    meta.status        = ST_OK;
                    meta.packet_length = PKT_LEN_W'(head_len);
                    if (head_len == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        st_re           = 1'b1;
                        st_raddr        = byte_addr(read_slot_reg, LEN_W'(read_offset_reg));
                        meta.from_store = 1'b1;
                        roff_new        = LEN_W'(read_offset_reg) + LEN_W'(1);
                        done            = (roff_new == head_len);
                        read_offset_next = OFF_W'(roff_new);
                    end
                    meta.last = done;
                    if (done)
                    begin
                        read_offset_next = '0;
                        read_slot_next   = slot_inc(read_slot_reg);
                    end
                end
            end
        end

        // The length table is read at the slot that will be the head next cycle.
        lt_raddr = read_slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg      <= '0;
            read_slot_reg       <= '0;
            write_offset_reg    <= '0;
            read_offset_reg     <= '0;
            dropping_packet_reg <= 1'b0;
            mid_packet_reg      <= 1'b0;
        end
        else
        begin
            write_slot_reg      <= write_slot_next;
            read_slot_reg       <= read_slot_next;
            write_offset_reg    <= write_offset_next;
            read_offset_reg     <= read_offset_next;
            dropping_packet_reg <= dropping_packet_next;
            mid_packet_reg      <= mid_packet_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/packet_receive_ring_queue.sv
// Top level of the packet receive ring queue: channel registers and handshakes.
// Uses prrq_pkg, prrq_engine, prrq_len_table and prrq_store.
//
//   Port group        Direction  Word type    Handshake
//   in_*              in         in_item_t    in_valid / in_stall
//   out_*             out        out_item_t   out_valid / out_stall
//   cfg_write_*       in         1 bit        cfg_write_en, no wait
//
// One word is taken every cycle while the result side does not stall; its result
// passes through the input register and then the result register, which is fed
// by the byte store read port. Throughput is set by the single store read and
// write port per cycle.
// Reset clears the ring pointers and the enable; the store and length table
// are not cleared. A stall of a valid result holds the result register and,
// if the input register holds a word, holds it too and raises in_stall in the
// same cycle.
`default_nettype none

module packet_receive_ring_queue #(
    parameter int QUEUE_SLOTS = prrq_pkg::QUEUE_SLOTS_DEF,
    parameter int SLOT_BYTES  = prrq_pkg::SLOT_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire prrq_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output prrq_pkg::out_item_t      out_data,
    input  wire logic                cfg_write_en,
    input  wire logic                cfg_write_data
);
    import prrq_pkg::*;

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int DEPTH  = QUEUE_SLOTS * SLOT_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic      enabled_reg;
    logic      p_valid_reg, p_valid_next;
    in_item_t  p_item_reg;
    logic      r_valid_reg, r_valid_next;
    res_meta_t r_meta_reg;

    logic              r_load;
    logic              fire;
    res_meta_t         meta;
    logic [LEN_W-1:0]  head_len;
    logic              lt_we;
    logic [SLOT_W-1:0] lt_waddr;
    logic [LEN_W-1:0]  lt_wdata;
    logic [SLOT_W-1:0] lt_raddr;
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [7:0]        st_wdata;
    logic              st_re;
    logic [ADDR_W-1:0] st_raddr;
    logic [7:0]        st_rdata;

    assign r_load   = !r_valid_reg || !out_stall;
    assign fire     = p_valid_reg && r_load;
    assign in_stall = p_valid_reg && !r_load;

    assign p_valid_next = (in_valid && !in_stall) || (p_valid_reg && !r_load);
    assign r_valid_next = r_load ? p_valid_reg : r_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                enabled_reg <= cfg_write_data;
            end
            p_valid_reg <= p_valid_next;
            r_valid_reg <= r_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            p_item_reg <= in_data;
        end
        if (fire)
        begin
            r_meta_reg <= meta;
        end
    end

    prrq_engine #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (p_item_reg),
        .enabled  (enabled_reg),
        .head_len (head_len),
        .meta     (meta),
        .lt_we    (lt_we),
        .lt_waddr (lt_waddr),
        .lt_wdata (lt_wdata),
        .lt_raddr (lt_raddr),
        .st_we    (st_we),
        .st_waddr (st_waddr),
        .st_wdata (st_wdata),
        .st_re    (st_re),
        .st_raddr (st_raddr)
    );

    prrq_len_table #(
        .DEPTH (QUEUE_SLOTS),
        .WIDTH (LEN_W)
    ) u_len_table (
        .clk   (clk),
        .we    (lt_we),
        .waddr (lt_waddr),
        .wdata (lt_wdata),
        .raddr (lt_raddr),
        .rdata (head_len)
    );

    prrq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign out_valid              = r_valid_reg;
    assign out_data.status        = r_meta_reg.status;
    assign out_data.out_byte      = r_meta_reg.from_store ? st_rdata : 8'd0;
    assign out_data.packet_length = r_meta_reg.packet_length;
    assign out_data.last          = r_meta_reg.last;

endmodule

`default_nettype wire

>>> tb/packet_receive_ring_queue_tb.sv
// Self-checking testbench for packet_receive_ring_queue: a clocked driver and monitor
// around uut, with a word-level model of the packet ring that predicts every result.
// Depends on prrq_pkg and the RTL top level packet_receive_ring_queue.
module packet_receive_ring_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prrq_pkg::*;

    localparam int SLOTS = QUEUE_SLOTS_DEF;
    localparam int BYTES = SLOT_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_write_en = 1'b0;
    logic      cfg_write_data = 1'b0;

    packet_receive_ring_queue uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #1 clk = ~clk;

    // Ring model state.
    logic [7:0]           byte_mem [SLOTS*BYTES];
    logic [PKT_LEN_W-1:0] len_mem [SLOTS];
    int unsigned          wr_slot = 0;
    int unsigned          rd_slot = 0;
    int unsigned          wr_off = 0;
    int unsigned          rd_off = 0;
    bit                   mid_pkt = 1'b0;
    bit                   dropping = 1'b0;
    bit                   enabled = 1'b0;

    in_item_t  pending_words[$];
    out_item_t expected_words[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int word_count = 0;
    bit no_idle = 1'b0;

    function automatic int unsigned next_slot(int unsigned s);
        return (s + 1 >= SLOTS) ? 0 : s + 1;
    endfunction

    function automatic out_item_t ring_step(in_item_t w);
        out_item_t   r;
        int unsigned len;
        bit          done;
        r = '0;
        if (!enabled)
        begin
            r.status = ST_DISABLED;
            return r;
        end
        if (w.opcode == OP_PUSH)
        begin
            // The slot check happens only on the first word of a packet.
            if (!mid_pkt)
            begin
                mid_pkt = 1'b1;
                wr_off = 0;
                dropping = (next_slot(wr_slot) == rd_slot);
            end
            if (dropping)
            begin
                if (w.last_byte)
                begin
                    mid_pkt = 1'b0;
                    dropping = 1'b0;
                end
                r.status = ST_DROPPED;
                r.last = w.last_byte;
                return r;
            end
            if (w.carries_byte)
            begin
                if (wr_off < BYTES)
                begin
                    byte_mem[wr_slot*BYTES + wr_off] = w.data_byte;
                    wr_off++;
                end
                else
                    r.status = ST_TRUNCATED;
            end
            if (w.last_byte)
            begin
                len_mem[wr_slot] = PKT_LEN_W'(wr_off);
                r.packet_length = PKT_LEN_W'(wr_off);
                r.last = 1'b1;
                wr_slot = next_slot(wr_slot);
                mid_pkt = 1'b0;
                wr_off = 0;
            end
            return r;
        end
        if (rd_slot == wr_slot)
        begin
            r.status = ST_EMPTY;
            return r;
        end
        len = 32'(len_mem[rd_slot]);
        r.packet_length = PKT_LEN_W'(len);
        if (len == 0)
            done = 1'b1;
        else
        begin
            r.out_byte = byte_mem[rd_slot*BYTES + rd_off];
            rd_off++;
            done = (rd_off >= len);
        end
        if (done)
        begin
            r.last = 1'b1;
            rd_off = 0;
            rd_slot = next_slot(rd_slot);
        end
        return r;
    endfunction

    function automatic void check_word(out_item_t got);
        out_item_t want;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: status=%0d byte=%02h len=%0d last=%0d",
                         got.status, got.out_byte, got.packet_length, got.last);
            return;
        end
        want = expected_words.pop_front();
        if (got.status !== want.status || got.out_byte !== want.out_byte ||
            got.packet_length !== want.packet_length || got.last !== want.last)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch: expected status=%0d byte=%02h len=%0d last=%0d,",
                         want.status, want.out_byte, want.packet_length, want.last);
                $display("          got status=%0d byte=%02h len=%0d last=%0d",
                         got.status, got.out_byte, got.packet_length, got.last);
            end
        end
    endfunction

    // Mostly short idle runs, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 200);
    endfunction

    function automatic void add_word(logic op, logic [7:0] b, logic lst, logic car);
        in_item_t w;
        w.opcode = op;
        w.data_byte = b;
        w.last_byte = lst;
        w.carries_byte = car;
        pending_words.push_back(w);
        if (enabled)
            word_count++;
    endfunction

    // The byte and marker bits of a pop word are ignored, so they are random.
    function automatic void add_pop();
        add_word(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    endfunction

    function automatic void add_noise();
        add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void add_packet(int n, int pop_pct);
        bit tail_empty;
        int i;
        tail_empty = (n == 0) || ($urandom_range(0, 9) == 0);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < pop_pct)
                add_pop();
            if ($urandom_range(0, 19) == 0)
                add_word(OP_PUSH, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            add_word(OP_PUSH, 8'($urandom_range(0, 255)), (i == n - 1) && !tail_empty, 1'b1);
        end
        if (tail_empty)
            add_word(OP_PUSH, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
    endfunction

    // Checked at the falling edge, where every update of the rising edge has settled.
    task automatic settle();
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_enable(logic v);
        settle();
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        enabled = v;
    endtask

    // Driver: a word stays on in_data until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_words.push_back(ring_step(in_data));
            if (!in_valid || !in_stall)
            begin
                if (gap_left == 0 && !no_idle)
                    gap_left = idle_len();
                if (gap_left != 0 || pending_words.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_words.pop_front();
                end
            end
        end
    end

    // Monitor: checks each accepted result word and drives random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            quiet_cycles = 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (out_valid && !out_stall)
                check_word(out_data);
            if (stall_left == 0 && !no_idle)
                stall_left = idle_len();
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int i;
        int base;
        int kind;
        int pop_pct;
        int r;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The enable is clear after reset, so both operations are refused.
        add_word(OP_PUSH, 8'hFF, 1'b1, 1'b1);
        add_word(OP_POP, 8'h00, 1'b0, 1'b0);
        set_enable(1'b1);

        add_word(OP_POP, 8'hFF, 1'b1, 1'b1);
        add_word(OP_PUSH, 8'h00, 1'b1, 1'b0);
        add_pop();
        add_word(OP_PUSH, 8'hFF, 1'b0, 1'b0);
        add_word(OP_PUSH, 8'h00, 1'b0, 1'b1);
        add_word(OP_PUSH, 8'hFF, 1'b1, 1'b1);
        // The packet being written must stay unreadable until its last word.
        add_word(OP_PUSH, 8'hA5, 1'b0, 1'b1);
        add_pop();
        add_pop();
        add_pop();
        add_word(OP_PUSH, 8'h5A, 1'b1, 1'b1);
        add_pop();
        add_pop();
        // Disabling in the middle of a packet neither ends nor cancels it.
        add_word(OP_PUSH, 8'h33, 1'b0, 1'b1);
        set_enable(1'b0);
        add_word(OP_PUSH, 8'h44, 1'b1, 1'b1);
        add_word(OP_POP, 8'h00, 1'b1, 1'b0);
        set_enable(1'b1);
        add_word(OP_PUSH, 8'h55, 1'b0, 1'b1);
        add_word(OP_PUSH, 8'h00, 1'b1, 1'b0);
        add_pop();
        add_pop();

        // An overlong packet whose last two bytes are discarded, then one that fills a slot.
        for (i = 0; i < BYTES + 2; i++)
            add_word(OP_PUSH, 8'($urandom_range(0, 255)), i == BYTES + 1, 1'b1);
        for (i = 0; i < BYTES; i++)
            add_pop();
        for (i = 0; i < BYTES; i++)
            add_word(OP_PUSH, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
        add_word(OP_PUSH, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
        for (i = 0; i < BYTES; i++)
            add_pop();
        settle();

        base = word_count;
        while (word_count - base < RANDOM_WORDS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 3);
            if (kind == 0)
            begin
                // Enough short packets to fill the ring and drop some.
                repeat (20) add_packet($urandom_range(0, 4), 0);
            end
            else if (kind == 3)
            begin
                repeat (60) add_pop();
            end
            else
            begin
                pop_pct = (kind == 1) ? 20 : 70;
                repeat ($urandom_range(4, 12))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        add_noise();
                    else if (r < pop_pct)
                        repeat ($urandom_range(1, 10)) add_pop();
                    else
                        add_packet(pick_len(), pop_pct / 3);
                end
            end
            settle();
            if ($urandom_range(0, 3) == 0)
            begin
                set_enable(1'b0);
                repeat ($urandom_range(4, 12)) add_noise();
                set_enable(1'b1);
            end
        end
        no_idle = 1'b0;
        settle();

        if (mismatches == 0 && expected_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
